/* src/tun_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Shared constants and width helpers for the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

  // Depth of the queues between the front, the back and the result port.
  localparam int QUEUE_DEPTH = 4;

  // Width of a cross product magnitude for a given coordinate width.
  // |w| <= 2 * (2^cw)^2, so 2*cw+2 unsigned bits hold it.
  function automatic int mag_width(input int cw);
    return 2 * cw + 2;
  endfunction

endpackage

/* src/triangle_unit_normal_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle unit normal core
// Unit face normal of one triangle per item, fully pipelined.
// ----------------------------------------------------------------------------
// The input side looks like a queue: drive the nine vertex coordinates and
// raise push; the item is taken at a clock edge where push is high and full
// is low. The result side looks like a queue as well: while empty is low the
// oldest result sits on normal_x/y/z and degenerate, and raising pop takes it.
//
// The front end forms the edge vectors and the exact cross product in three
// stages. A short queue separates it from the back end, which scales the
// cross product (two shift stages), sums the squares (two stages), takes the
// integer square root one bit per stage (32 stages) and divides the three
// components in restoring dividers, one quotient bit per stage
// (NORMAL_FRACTION_BITS + 1 stages). A result queue holds finished items.
//
// Throughput is one item per cycle when nothing stalls. With
// the default NORMAL_FRACTION_BITS the square root chain is the longest
// part of the pipeline. When the receiver stops popping, the result queue
// fills, the back end halts, then the middle queue fills and full rises; no
// item is dropped. A degenerate triangle gives a zero normal with degenerate
// set. Reset clears all valid bits and queue pointers.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core #(
  parameter int COORD_WIDTH          = 32,
  parameter int NORMAL_FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [COORD_WIDTH-1:0]          a_x,
  input  logic [COORD_WIDTH-1:0]          a_y,
  input  logic [COORD_WIDTH-1:0]          a_z,
  input  logic [COORD_WIDTH-1:0]          b_x,
  input  logic [COORD_WIDTH-1:0]          b_y,
  input  logic [COORD_WIDTH-1:0]          b_z,
  input  logic [COORD_WIDTH-1:0]          c_x,
  input  logic [COORD_WIDTH-1:0]          c_y,
  input  logic [COORD_WIDTH-1:0]          c_z,
  output logic                            empty,
  input  logic                            pop,
  output logic [NORMAL_FRACTION_BITS+1:0] normal_x,
  output logic [NORMAL_FRACTION_BITS+1:0] normal_y,
  output logic [NORMAL_FRACTION_BITS+1:0] normal_z,
  output logic                            degenerate
);
  import tun_pkg::*;

  localparam int MW = mag_width(COORD_WIDTH);
  localparam int NO = NORMAL_FRACTION_BITS + 2;

  logic              front_ready;
  logic              front_valid;
  logic [3*MW+3:0]   front_data;
  logic              mid_full;
  logic              mid_empty;
  logic              mid_pop;
  logic [3*MW+3:0]   mid_data;
  logic              res_push;
  logic              res_full;
  logic [3*NO:0]     res_data;
  logic [3*NO:0]     out_data;

  assign full = !front_ready;

  tun_front #(
    .CW (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (front_ready),
    .a_x       (a_x),
    .a_y       (a_y),
    .a_z       (a_z),
    .b_x       (b_x),
    .b_y       (b_y),
    .b_z       (b_z),
    .c_x       (c_x),
    .c_y       (c_y),
    .c_z       (c_z),
    .out_valid (front_valid),
    .out_full  (mid_full),
    .out_data  (front_data)
  );

  tun_fifo #(
    .WIDTH (3 * MW + 4),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .full  (mid_full),
    .din   (front_data),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_data)
  );

  tun_back #(
    .CW (COORD_WIDTH),
    .NF (NORMAL_FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (mid_empty),
    .in_pop   (mid_pop),
    .in_data  (mid_data),
    .out_push (res_push),
    .out_full (res_full),
    .out_data (res_data)
  );

  tun_fifo #(
    .WIDTH (3 * NO + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_data),
    .pop   (pop),
    .empty (empty),
    .dout  (out_data)
  );

  assign normal_x   = out_data[3*NO -: NO];
  assign normal_y   = out_data[2*NO -: NO];
  assign normal_z   = out_data[NO -: NO];
  assign degenerate = out_data[0];

endmodule

/* src/tun_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register queue
// A short first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tun_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + NW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

/* src/tun_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle unit normal front end
// Takes vertices, forms edge vectors and the exact cross product, and
// classifies the triangle as degenerate or not.
// ----------------------------------------------------------------------------
module tun_front #(
  parameter  int CW = 32,
  localparam int MW = tun_pkg::mag_width(CW)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CW-1:0]     a_x,
  input  logic [CW-1:0]     a_y,
  input  logic [CW-1:0]     a_z,
  input  logic [CW-1:0]     b_x,
  input  logic [CW-1:0]     b_y,
  input  logic [CW-1:0]     b_z,
  input  logic [CW-1:0]     c_x,
  input  logic [CW-1:0]     c_y,
  input  logic [CW-1:0]     c_z,
  output logic              out_valid,
  input  logic              out_full,
  output logic [3*MW+3:0]   out_data
);
  import tun_pkg::*;

  localparam int PW = 2 * CW + 2;

  logic                     en;
  logic                     v1, v2, v3;
  logic signed [CW:0]       u_q [3];
  logic signed [CW:0]       v_q [3];
  logic signed [CW:0]       u_d [3];
  logic signed [CW:0]       v_d [3];
  logic signed [PW-1:0]     p_q [6];
  logic signed [PW:0]       w_d [3];
  logic [MW-1:0]            m_d [3];
  logic [MW-1:0]            m_q [3];
  logic [2:0]               neg_q;
  logic                     dg_q;

  assign en        = !(v3 && out_full);
  assign in_ready  = en;
  assign out_valid = v3;
  assign out_data  = {m_q[2], m_q[1], m_q[0], neg_q, dg_q};

  assign u_d[0] = $signed({a_x[CW-1], a_x}) - $signed({b_x[CW-1], b_x});
  assign u_d[1] = $signed({a_y[CW-1], a_y}) - $signed({b_y[CW-1], b_y});
  assign u_d[2] = $signed({a_z[CW-1], a_z}) - $signed({b_z[CW-1], b_z});
  assign v_d[0] = $signed({b_x[CW-1], b_x}) - $signed({c_x[CW-1], c_x});
  assign v_d[1] = $signed({b_y[CW-1], b_y}) - $signed({c_y[CW-1], c_y});
  assign v_d[2] = $signed({b_z[CW-1], b_z}) - $signed({c_z[CW-1], c_z});

  // Cross product components from the registered products.
  assign w_d[0] = {p_q[0][PW-1], p_q[0]} - {p_q[1][PW-1], p_q[1]};
  assign w_d[1] = {p_q[2][PW-1], p_q[2]} - {p_q[3][PW-1], p_q[3]};
  assign w_d[2] = {p_q[4][PW-1], p_q[4]} - {p_q[5][PW-1], p_q[5]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i] = w_d[i][PW] ? MW'(-w_d[i]) : MW'(w_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= u_d[i];
        v_q[i] <= v_d[i];
        m_q[i] <= m_d[i];
        neg_q[i] <= w_d[i][PW];
      end
      p_q[0] <= u_q[1] * v_q[2];
      p_q[1] <= u_q[2] * v_q[1];
      p_q[2] <= u_q[2] * v_q[0];
      p_q[3] <= u_q[0] * v_q[2];
      p_q[4] <= u_q[0] * v_q[1];
      p_q[5] <= u_q[1] * v_q[0];
      dg_q <= (w_d[0] == '0) && (w_d[1] == '0) && (w_d[2] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

endmodule

/* src/tun_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle unit normal back end
// Scales the cross product, takes its length by a pipelined square root and
// divides each component by it in pipelined restoring dividers.
// ----------------------------------------------------------------------------
module tun_back #(
  parameter  int CW = 32,
  parameter  int NF = 16,
  localparam int MW = tun_pkg::mag_width(CW),
  localparam int NO = NF + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_empty,
  output logic              in_pop,
  input  logic [3*MW+3:0]   in_data,
  output logic              out_push,
  input  logic              out_full,
  output logic [3*NO:0]     out_data
);
  import tun_pkg::*;

  localparam int NC  = (MW + 7) / 8;
  localparam int OPW = NC * 8;
  localparam int KW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int XW  = MW + 31;
  localparam int NW  = 32 + NF;

  typedef struct packed {
    logic [2:0][30:0] sm;
    logic [2:0]       neg;
    logic             dg;
  } pay_t;

  function automatic logic [3:0] blen8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  logic en;

  // Stage 0: capture from the queue.
  logic            b0_v;
  logic [MW-1:0]   b0_m [3];
  logic [2:0]      b0_neg;
  logic            b0_dg;
  // Stage 1: coarse shift by whole bytes.
  logic            b1_v;
  logic [XW-1:0]   b1_x [3];
  logic [7:0]      b1_byte;
  logic [2:0]      b1_neg;
  logic            b1_dg;
  // Stage 2: fine shift.
  logic            b2_v;
  pay_t            b2_p;
  // Stage 3: squares.
  logic            b3_v;
  logic [61:0]     b3_sq [3];
  pay_t            b3_p;

  logic [OPW-1:0]  opad;
  logic [NC-1:0]   nz;
  logic [KW-1:0]   kc;
  logic [3:0]      fine;

  // Square root pipeline, index 0 is the sum of squares.
  logic            sq_v [33];
  logic [63:0]     sq_s [33];
  logic [63:0]     sq_r [33];
  pay_t            sq_p [33];

  // Divider pipeline, index 0 is the prepared numerator.
  logic              dv_v   [NF+2];
  logic [2:0][32:0]  dv_rem [NF+2];
  logic [2:0][NF:0]  dv_n   [NF+2];
  logic [2:0][NF:0]  dv_q   [NF+2];
  logic [31:0]       dv_l   [NF+2];
  logic [2:0]        dv_neg [NF+2];
  logic              dv_dg  [NF+2];

  logic [2:0][NW-1:0] num;
  logic [NO-1:0]      res [3];

  assign en     = !(dv_v[NF+1] && out_full);
  assign in_pop = en && !in_empty;

  assign opad = OPW'(b0_m[0] | b0_m[1] | b0_m[2]);

  always_comb begin
    kc = '0;
    for (int k = 0; k < NC; k++) begin
      nz[k] = |opad[k*8 +: 8];
      if (nz[k]) kc = KW'(k);
    end
  end

  assign fine = blen8(b1_byte);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq_p[32].sm[i], {NF{1'b0}}} + NW'(sq_r[32][31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_m[0] <= in_data[4 +: MW];
      b0_m[1] <= in_data[MW+4 +: MW];
      b0_m[2] <= in_data[2*MW+4 +: MW];
      b0_neg  <= in_data[3:1];
      b0_dg   <= in_data[0];

      for (int i = 0; i < 3; i++) begin
        b1_x[i] <= {b0_m[i], 31'b0} >> {kc, 3'b000};
      end
      b1_byte <= opad[kc*8 +: 8];
      b1_neg  <= b0_neg;
      b1_dg   <= b0_dg;

      for (int i = 0; i < 3; i++) begin
        b2_p.sm[i] <= 31'(b1_x[i] >> fine);
      end
      b2_p.neg <= b1_neg;
      b2_p.dg  <= b1_dg;

      for (int i = 0; i < 3; i++) begin
        b3_sq[i] <= b2_p.sm[i] * b2_p.sm[i];
      end
      b3_p <= b2_p;

      sq_s[0] <= 64'(b3_sq[0]) + 64'(b3_sq[1]) + 64'(b3_sq[2]);
      sq_r[0] <= '0;
      sq_p[0] <= b3_p;

      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= 33'(num[i][NW-1:NF+1]);
        dv_n[0][i]   <= num[i][NF:0];
        dv_q[0][i]   <= '0;
      end
      dv_l[0]   <= sq_r[32][31:0];
      dv_neg[0] <= sq_p[32].neg;
      dv_dg[0]  <= sq_p[32].dg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v     <= 1'b0;
      b1_v     <= 1'b0;
      b2_v     <= 1'b0;
      b3_v     <= 1'b0;
      sq_v[0]  <= 1'b0;
      dv_v[0]  <= 1'b0;
    end else if (en) begin
      b0_v    <= !in_empty;
      b1_v    <= b0_v;
      b2_v    <= b1_v;
      b3_v    <= b2_v;
      sq_v[0] <= b3_v;
      dv_v[0] <= sq_v[32];
    end
  end

  // One root bit per stage.
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sq_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_s[j] >= trial) begin
          sq_s[j+1] <= sq_s[j] - trial;
          sq_r[j+1] <= (sq_r[j] >> 1) + BIT;
        end else begin
          sq_s[j+1] <= sq_s[j];
          sq_r[j+1] <= sq_r[j] >> 1;
        end
        sq_p[j+1] <= sq_p[j];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
    end
  end

  // One quotient bit per stage for each of the three lanes.
  for (genvar t = 0; t <= NF; t++) begin : g_div
    logic [2:0][32:0] cand;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = {dv_rem[t][i][31:0], dv_n[t][i][NF-t]};
        ge[i]   = (cand[i] >= {1'b0, dv_l[t]});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[t+1][i] <= ge[i] ? cand[i] - {1'b0, dv_l[t]} : cand[i];
          dv_q[t+1][i]   <= {dv_q[t][i][NF-1:0], ge[i]};
        end
        dv_n[t+1]   <= dv_n[t];
        dv_l[t+1]   <= dv_l[t];
        dv_neg[t+1] <= dv_neg[t];
        dv_dg[t+1]  <= dv_dg[t];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[t+1] <= 1'b0;
      end else if (en) begin
        dv_v[t+1] <= dv_v[t];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_dg[NF+1]) begin
        res[i] = '0;
      end else if (dv_neg[NF+1][i]) begin
        res[i] = -NO'(dv_q[NF+1][i]);
      end else begin
        res[i] = NO'(dv_q[NF+1][i]);
      end
    end
  end

  assign out_push = dv_v[NF+1] && !out_full;
  assign out_data = {res[0], res[1], res[2], dv_dg[NF+1]};

endmodule
